// ----- src/ptw_pkg.sv -----
`default_nettype none

package ptw_pkg;

	localparam int TABLE_POOL = 64;
	localparam int LEVELS     = 4;
	localparam int INDEX_BITS = 9;
	localparam int PAGE_BITS  = 12;

	localparam int VA_W   = 48;
	localparam int PA_W   = 64;
	localparam int SLOTS  = 1 << INDEX_BITS;
	localparam int TBL_W  = $clog2(TABLE_POOL);
	localparam int NF_W   = $clog2(TABLE_POOL + 1);
	localparam int ADDR_W = TBL_W + INDEX_BITS;
	localparam int DEPTH  = TABLE_POOL * SLOTS;
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int LAST   = LEVELS - 1;
	localparam int STEP_W = 4;

	localparam logic [0:0] OP_MAP    = 1'b0;
	localparam logic [0:0] OP_LOOKUP = 1'b1;

	localparam logic [2:0] MEM_NONE     = 3'd0;
	localparam logic [2:0] MEM_CLR_ROOT = 3'd1;
	localparam logic [2:0] MEM_CLR_NEW  = 3'd2;
	localparam logic [2:0] MEM_RD_DIR   = 3'd3;
	localparam logic [2:0] MEM_WR_PTR   = 3'd4;
	localparam logic [2:0] MEM_LEAF     = 3'd5;

	localparam logic [2:0] DP_NONE   = 3'd0;
	localparam logic [2:0] DP_ACCEPT = 3'd1;
	localparam logic [2:0] DP_WALK   = 3'd2;
	localparam logic [2:0] DP_FILL   = 3'd3;
	localparam logic [2:0] DP_ALLOC  = 3'd4;
	localparam logic [2:0] DP_DONE   = 3'd5;
	localparam logic [2:0] DP_FAIL   = 3'd6;

	localparam logic [2:0] C_NEVER     = 3'd0;
	localparam logic [2:0] C_NO_BEAT   = 3'd1;
	localparam logic [2:0] C_FILL_MORE = 3'd2;
	localparam logic [2:0] C_DIR_MORE  = 3'd3;
	localparam logic [2:0] C_SHORT     = 3'd4;
	localparam logic [2:0] C_LAST      = 3'd5;
	localparam logic [2:0] C_OUT_BUSY  = 3'd6;

	localparam logic [STEP_W-1:0] S_RFILL = 4'd0;
	localparam logic [STEP_W-1:0] S_IDLE  = 4'd1;
	localparam logic [STEP_W-1:0] S_DRD   = 4'd2;
	localparam logic [STEP_W-1:0] S_DEVAL = 4'd3;
	localparam logic [STEP_W-1:0] S_CHECK = 4'd4;
	localparam logic [STEP_W-1:0] S_ATEST = 4'd5;
	localparam logic [STEP_W-1:0] S_AFILL = 4'd6;
	localparam logic [STEP_W-1:0] S_ALLOC = 4'd7;
	localparam logic [STEP_W-1:0] S_LEAF  = 4'd8;
	localparam logic [STEP_W-1:0] S_RES   = 4'd9;
	localparam logic [STEP_W-1:0] S_FAIL  = 4'd10;

	typedef struct packed {
		logic [2:0]        mem_op;
		logic [2:0]        dp_op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] jmp;
		logic [STEP_W-1:0] nxt;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic fill_last;
		logic dir_done;
		logic pool_short;
		logic at_last;
		logic out_busy;
	} flags_t;

	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t c;
		c = '{MEM_NONE, DP_NONE, C_NEVER, S_IDLE, S_IDLE};
		unique case (step)
			S_RFILL: c = '{MEM_CLR_ROOT, DP_FILL,   C_FILL_MORE, S_RFILL, S_IDLE};
			S_IDLE:  c = '{MEM_NONE,     DP_ACCEPT, C_NO_BEAT,   S_IDLE,  S_DRD};
			S_DRD:   c = '{MEM_RD_DIR,   DP_NONE,   C_NEVER,     S_DRD,   S_DEVAL};
			S_DEVAL: c = '{MEM_NONE,     DP_WALK,   C_DIR_MORE,  S_DRD,   S_CHECK};
			S_CHECK: c = '{MEM_NONE,     DP_NONE,   C_SHORT,     S_FAIL,  S_ATEST};
			S_ATEST: c = '{MEM_NONE,     DP_NONE,   C_LAST,      S_LEAF,  S_AFILL};
			S_AFILL: c = '{MEM_CLR_NEW,  DP_FILL,   C_FILL_MORE, S_AFILL, S_ALLOC};
			S_ALLOC: c = '{MEM_WR_PTR,   DP_ALLOC,  C_NEVER,     S_ATEST, S_ATEST};
			S_LEAF:  c = '{MEM_LEAF,     DP_NONE,   C_NEVER,     S_RES,   S_RES};
			S_RES:   c = '{MEM_NONE,     DP_DONE,   C_OUT_BUSY,  S_RES,   S_IDLE};
			S_FAIL:  c = '{MEM_NONE,     DP_FAIL,   C_OUT_BUSY,  S_FAIL,  S_IDLE};
			default: c = '{MEM_NONE,     DP_NONE,   C_NEVER,     S_IDLE,  S_IDLE};
		endcase
		return c;
	endfunction

	function automatic logic [INDEX_BITS-1:0] level_index(input logic [VA_W-1:0] va,
			input logic [LVL_W-1:0] lvl);
		logic [INDEX_BITS-1:0] idx;
		idx = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (LVL_W'(l) == lvl) begin
				idx = INDEX_BITS'(va >> (PAGE_BITS + INDEX_BITS * (LEVELS - 1 - l)));
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- src/ptw_if.sv -----
`default_nettype none

interface ptw_req_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [ptw_pkg::VA_W-1:0]    vaddr;
	logic [ptw_pkg::PA_W-1:0]    paddr;

	modport source (output valid, output opcode, output vaddr, output paddr, input ready);
	modport sink   (input valid, input opcode, input vaddr, input paddr, output ready);
endinterface

interface ptw_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ptw_pkg::PA_W-1:0]    leaf_value;
	logic                        status;

	modport source (output valid, output leaf_value, output status, input ready);
	modport sink   (input valid, input leaf_value, input status, output ready);
endinterface

`default_nettype wire

// ----- src/ptw_seq.sv -----
`default_nettype none

module ptw_seq (
	input  wire               clk,
	input  wire               arst_n,
	input  ptw_pkg::flags_t   flags,
	output ptw_pkg::ctl_t     ctl
);

	logic [ptw_pkg::STEP_W-1:0] step_q;
	logic                       take;

	assign ctl = ptw_pkg::ucode(step_q);

	always_comb begin
		unique case (ctl.cond)
			ptw_pkg::C_NEVER:     take = 1'b0;
			ptw_pkg::C_NO_BEAT:   take = !flags.in_valid;
			ptw_pkg::C_FILL_MORE: take = !flags.fill_last;
			ptw_pkg::C_DIR_MORE:  take = !flags.dir_done;
			ptw_pkg::C_SHORT:     take = flags.pool_short;
			ptw_pkg::C_LAST:      take = flags.at_last;
			ptw_pkg::C_OUT_BUSY:  take = flags.out_busy;
			default:              take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ptw_pkg::S_RFILL;
		end else begin
			step_q <= take ? ctl.jmp : ctl.nxt;
		end
	end

endmodule

`default_nettype wire

// ----- src/ptw_dp.sv -----
`default_nettype none

module ptw_dp (
	input  wire               clk,
	input  wire               arst_n,
	ptw_req_if.sink           req,
	ptw_rsp_if.source         rsp,
	input  ptw_pkg::ctl_t     ctl,
	output ptw_pkg::flags_t   flags
);

	logic [ptw_pkg::PA_W-1:0]       mem [ptw_pkg::DEPTH];

	logic                           op_q;
	logic [ptw_pkg::VA_W-1:0]       va_q;
	logic [ptw_pkg::PA_W-1:0]       pa_q;
	logic [ptw_pkg::TBL_W-1:0]      t_q;
	logic [ptw_pkg::LVL_W-1:0]      lvl_q;
	logic [ptw_pkg::NF_W-1:0]       nf_q;
	logic [ptw_pkg::INDEX_BITS-1:0] cnt_q;
	logic [ptw_pkg::PA_W-1:0]       rd_q;
	logic                           out_valid_q;
	logic [ptw_pkg::PA_W-1:0]       out_leaf_q;
	logic                           out_status_q;

	logic [ptw_pkg::INDEX_BITS-1:0] idx;
	logic [ptw_pkg::ADDR_W-1:0]     addr;
	logic                           we;
	logic                           re;
	logic [ptw_pkg::PA_W-1:0]       wdata;
	logic [ptw_pkg::TBL_W-1:0]      child;
	logic [ptw_pkg::NF_W:0]         need_end;
	logic                           accept;
	logic                           load_out;

	assign idx = ptw_pkg::level_index(va_q, lvl_q);
	assign child = (rd_q >= ptw_pkg::PA_W'(ptw_pkg::TABLE_POOL)) ? '0
		: rd_q[ptw_pkg::TBL_W-1:0];
	assign need_end = (ptw_pkg::NF_W+1)'(nf_q) + (ptw_pkg::NF_W+1)'(ptw_pkg::LAST)
		- (ptw_pkg::NF_W+1)'(lvl_q);

	assign req.ready = (ctl.dp_op == ptw_pkg::DP_ACCEPT);
	assign accept = req.valid && req.ready;

	assign flags.in_valid   = req.valid;
	assign flags.fill_last  = (cnt_q == {ptw_pkg::INDEX_BITS{1'b1}});
	assign flags.dir_done   = (rd_q == '0)
		|| (lvl_q == ptw_pkg::LVL_W'(ptw_pkg::LAST - 1));
	assign flags.pool_short = (need_end > (ptw_pkg::NF_W+1)'(ptw_pkg::TABLE_POOL));
	assign flags.at_last    = (lvl_q == ptw_pkg::LVL_W'(ptw_pkg::LAST));
	assign flags.out_busy   = out_valid_q && !rsp.ready;

	assign load_out = ((ctl.dp_op == ptw_pkg::DP_DONE) || (ctl.dp_op == ptw_pkg::DP_FAIL))
		&& !flags.out_busy;

	assign rsp.valid      = out_valid_q;
	assign rsp.leaf_value = out_leaf_q;
	assign rsp.status     = out_status_q;

	// single port: address shared by reads and writes
	always_comb begin
		addr  = {t_q, idx};
		we    = 1'b0;
		re    = 1'b0;
		wdata = '0;
		unique case (ctl.mem_op)
			ptw_pkg::MEM_NONE: begin
			end
			ptw_pkg::MEM_CLR_ROOT: begin
				addr = {ptw_pkg::TBL_W'(0), cnt_q};
				we   = 1'b1;
			end
			ptw_pkg::MEM_CLR_NEW: begin
				addr = {nf_q[ptw_pkg::TBL_W-1:0], cnt_q};
				we   = 1'b1;
			end
			ptw_pkg::MEM_RD_DIR: begin
				re = 1'b1;
			end
			ptw_pkg::MEM_WR_PTR: begin
				we    = 1'b1;
				wdata = ptw_pkg::PA_W'(nf_q);
			end
			ptw_pkg::MEM_LEAF: begin
				we    = (op_q == ptw_pkg::OP_MAP);
				re    = (op_q == ptw_pkg::OP_LOOKUP);
				wdata = pa_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.opcode;
			va_q <= req.vaddr;
			pa_q <= req.paddr;
		end
		if (load_out) begin
			if (ctl.dp_op == ptw_pkg::DP_DONE) begin
				out_leaf_q   <= (op_q == ptw_pkg::OP_LOOKUP) ? rd_q : pa_q;
				out_status_q <= 1'b0;
			end else begin
				out_leaf_q   <= '0;
				out_status_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q         <= '0;
			lvl_q       <= '0;
			nf_q        <= ptw_pkg::NF_W'(1);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				t_q   <= '0;
				lvl_q <= '0;
			end
			if (ctl.dp_op == ptw_pkg::DP_WALK && rd_q != '0) begin
				t_q   <= child;
				lvl_q <= lvl_q + 1'b1;
			end
			if (ctl.dp_op == ptw_pkg::DP_FILL) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctl.dp_op == ptw_pkg::DP_ALLOC) begin
				t_q   <= nf_q[ptw_pkg::TBL_W-1:0];
				nf_q  <= nf_q + 1'b1;
				lvl_q <= lvl_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= ptw_pkg::NF_W'(ptw_pkg::TABLE_POOL))
		else $error("table count beyond pool");

	a_ptr_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.mem_op == ptw_pkg::MEM_WR_PTR || ctl.mem_op == ptw_pkg::MEM_CLR_NEW)
		|-> nf_q < ptw_pkg::NF_W'(ptw_pkg::TABLE_POOL))
		else $error("allocating a table outside the pool");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.dp_op == ptw_pkg::DP_ALLOC |=> nf_q == $past(nf_q) + 1'b1)
		else $error("allocation did not advance the free table");

	a_fill_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.dp_op == ptw_pkg::DP_ALLOC || ctl.dp_op == ptw_pkg::DP_ACCEPT) |-> cnt_q == '0)
		else $error("fill counter not at row start");

endmodule

`default_nettype wire

// ----- src/four_level_page_table_walker_unit.sv -----
// Four-level page table walker with 4 KiB pages.
// req channel: one beat per request carries opcode (0 map, 1 lookup), the
// 48-bit vaddr and, for map, the 64-bit paddr to store in the leaf entry.
// rsp channel: one beat per request carries leaf_value (looked-up entry, or
// the stored paddr on map) and status (1 when the table pool ran out, in
// which case nothing changed and leaf_value is 0).
// Control is a microprogram stepping through a single-port table memory,
// one access per step, with registered read data.
// A request whose tables all exist runs two steps per directory level plus
// check, level test, leaf and result steps. Each table allocated on the way
// adds a zero-fill of its 512 entries, one entry per cycle, one pointer
// write and one level test; directory levels below the missing entry are
// never read.
// One request is in flight at a time; the next req beat is taken once the
// previous result sits in the output register, even if not yet taken.
// After reset the root table's 512 entries are cleared while req.ready is low.
// When the receiver stalls, the result waits in the output register and the
// walker holds in its result or fail step until that register is free.
`default_nettype none

module four_level_page_table_walker_unit (
	input  wire          clk,
	input  wire          arst_n,
	ptw_req_if.sink      req,
	ptw_rsp_if.source    rsp
);

	ptw_pkg::ctl_t   ctl;
	ptw_pkg::flags_t flags;

	ptw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	ptw_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctl    (ctl),
		.flags  (flags)
	);

endmodule

`default_nettype wire
